// ===== rtl/rle_byte_stream_expander_unit_defines.svh =====
// Assertion macros for the run-length expander.
// Included by the RTL files that carry concurrent checks; needs nothing else.
`ifndef RLE_BYTE_STREAM_EXPANDER_UNIT_DEFINES_SVH
`define RLE_BYTE_STREAM_EXPANDER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define RBSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbse check failed");

// Next-cycle implication, disabled while reset is low
`define RBSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbse check failed");

`endif

// ===== rtl/rbse_pkg.sv =====
// Shared types and constants of the run-length expander.
// No dependencies; used by every module of the block.
package rbse_pkg;

  // Decoder phase
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_CONTROL = 2'd1,
    PH_LITERAL = 2'd2,
    PH_REPEAT  = 2'd3
  } phase_e;

  localparam logic [7:0] LitThreshold = 8'h80;
  localparam logic [7:0] LitOffset    = 8'h7F;
  localparam logic [7:0] RepOffset    = 8'd3;
  localparam logic [1:0] HeaderLast   = 2'd3;

  // One compressed input byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_item_t;

  // One decoded run
  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] run_count;
    logic       clipped;
    logic       end_of_output;
  } run_t;

endpackage

// ===== rtl/rbse_in_reg.sv =====
// Input register of the run-length expander.
// Depends on rbse_pkg for the input item type.
module rbse_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rbse_pkg::in_item_t in_item_i,
  output logic              item_valid_o,
  output rbse_pkg::in_item_t item_o,
  input  logic              item_take_i
);
  import rbse_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // Accept a transfer when empty or when the held item leaves this cycle
  assign in_ready_o = !valid_q || item_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold payload; no reset needed
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;
endmodule

// ===== rtl/rbse_core.sv =====
// Decode state and run computation of the run-length expander.
// Depends on rbse_pkg and the assertion macro header.
`include "rle_byte_stream_expander_unit_defines.svh"
module rbse_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  rbse_pkg::in_item_t item_i,
  output logic               item_take_o,
  input  logic               out_free_i,
  output logic               run_valid_o,
  output rbse_pkg::run_t     run_o
);
  import rbse_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  hdr_idx_q, hdr_idx_d;
  logic [31:0] limit_q, limit_d;
  logic [31:0] written_q, written_d;
  logic [7:0]  lit_left_q, lit_left_d;
  logic [7:0]  rep_len_q, rep_len_d;

  logic        emits;
  logic [7:0]  run_len;
  logic [31:0] room;
  logic [7:0]  take_cnt;
  logic [7:0]  lit_dec;
  run_t        run;

  // Data phases emit a run; the last byte always yields an item
  assign emits       = (phase_q == PH_LITERAL) || (phase_q == PH_REPEAT);
  assign run_valid_o = item_valid_i && (emits || item_i.stream_end);
  assign item_take_o = item_valid_i && (!run_valid_o || out_free_i);

  // Clip the run to the room left
  assign run_len  = (phase_q == PH_LITERAL) ? 8'd1 : rep_len_q;
  assign room     = limit_q - written_q;
  assign take_cnt = ({24'd0, run_len} < room) ? run_len : room[7:0];
  assign lit_dec  = lit_left_q - 8'd1;

  always_comb begin
    phase_d    = phase_q;
    hdr_idx_d  = hdr_idx_q;
    limit_d    = limit_q;
    written_d  = written_q;
    lit_left_d = lit_left_q;
    rep_len_d  = rep_len_q;
    run        = '0;
    run.end_of_output = item_i.stream_end;

    unique case (phase_q)
      PH_HEADER: begin
        limit_d = limit_q | ({24'd0, item_i.in_byte} << {hdr_idx_q, 3'b000});
        if (hdr_idx_q == HeaderLast) begin
          phase_d   = PH_CONTROL;
          hdr_idx_d = 2'd0;
        end else begin
          hdr_idx_d = hdr_idx_q + 2'd1;
        end
      end
      PH_CONTROL: begin
        if (item_i.in_byte >= LitThreshold) begin
          lit_left_d = item_i.in_byte - LitOffset;
          phase_d    = PH_LITERAL;
        end else begin
          rep_len_d = item_i.in_byte + RepOffset;
          phase_d   = PH_REPEAT;
        end
      end
      PH_LITERAL: begin
        lit_left_d = lit_dec;
        if (lit_dec == 8'd0) begin
          phase_d = PH_CONTROL;
        end
      end
      PH_REPEAT: begin
        phase_d = PH_CONTROL;
      end
      default: phase_d = PH_HEADER;
    endcase

    // Fill the run for data phases
    if (emits) begin
      written_d     = written_q + {24'd0, take_cnt};
      run.out_byte  = item_i.in_byte;
      run.run_count = take_cnt;
      run.clipped   = (take_cnt < run_len);
    end

    // Drop all state at the end of a stream
    if (item_i.stream_end) begin
      phase_d    = PH_HEADER;
      hdr_idx_d  = 2'd0;
      limit_d    = '0;
      written_d  = '0;
      lit_left_d = '0;
      rep_len_d  = '0;
    end
  end

  assign run_o = run;

  // Advance state on each consumed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      hdr_idx_q  <= 2'd0;
      limit_q    <= '0;
      written_q  <= '0;
      lit_left_q <= '0;
      rep_len_q  <= '0;
    end else if (item_take_o) begin
      phase_q    <= phase_d;
      hdr_idx_q  <= hdr_idx_d;
      limit_q    <= limit_d;
      written_q  <= written_d;
      lit_left_q <= lit_left_d;
      rep_len_q  <= rep_len_d;
    end
  end

  `RBSE_ASSERT_NOW(a_written_le_limit, clk_i, rst_ni, 1'b1, written_q <= limit_q)
  `RBSE_ASSERT_NOW(a_literal_pending, clk_i, rst_ni, phase_q == PH_LITERAL, lit_left_q != 8'd0)
  `RBSE_ASSERT_NEXT(a_end_restarts, clk_i, rst_ni, item_take_o && item_i.stream_end,
                    phase_q == PH_HEADER && written_q == 32'd0 && limit_q == 32'd0)
  `RBSE_ASSERT_NOW(a_clip_exact, clk_i, rst_ni, run_valid_o && emits && !run_o.clipped,
                   run_o.run_count == run_len)
endmodule

// ===== rtl/rbse_out_reg.sv =====
// Result register of the run-length expander.
// Depends on rbse_pkg for the run type.
module rbse_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           run_valid_i,
  input  logic           run_load_i,
  input  rbse_pkg::run_t run_i,
  output logic           out_free_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rbse_pkg::run_t run_o
);
  import rbse_pkg::*;

  logic valid_q, valid_d;
  run_t run_q;
  logic load;

  // Slot frees when empty or when the held run transfers now
  assign out_free_o = !valid_q || out_ready_i;
  assign load       = run_valid_i && run_load_i;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the run until transferred
  always_ff @(posedge clk_i) begin
    if (load) begin
      run_q <= run_i;
    end
  end

  assign out_valid_o = valid_q;
  assign run_o       = run_q;
endmodule

// ===== rtl/rle_byte_stream_expander_unit.sv =====
// Channel | direction | payload
// in      | sink      | in_byte_i[7:0], stream_end_i
// out     | source    | out_byte_o[7:0], run_count_o[7:0], clipped_o, end_of_output_o
//
// One byte per cycle while the output does not stall; a byte passes the input register,
// then its run is decoded into the result register, from which it transfers out.
// Header and control bytes free the input register without using the result slot, unless they end the stream.
// Reset clears phase, counters and both valid flags; no clearing pass.
// A stalled output holds its run; input keeps flowing until both registers are full.
// Top level of the run-length expander; depends on rbse_pkg, rbse_in_reg,
// rbse_core and rbse_out_reg.
module rle_byte_stream_expander_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       stream_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [7:0] run_count_o,
  output logic       clipped_o,
  output logic       end_of_output_o
);
  import rbse_pkg::*;

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     item_take;
  logic     out_free;
  logic     run_valid;
  run_t     run;
  run_t     run_out;

  assign in_item.in_byte    = in_byte_i;
  assign in_item.stream_end = stream_end_i;

  // Input register
  rbse_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  // Decode
  rbse_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .out_free_i   (out_free),
    .run_valid_o  (run_valid),
    .run_o        (run)
  );

  // Result register
  rbse_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_valid_i (run_valid),
    .run_load_i  (item_take),
    .run_i       (run),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .run_o       (run_out)
  );

  assign out_byte_o      = run_out.out_byte;
  assign run_count_o     = run_out.run_count;
  assign clipped_o       = run_out.clipped;
  assign end_of_output_o = run_out.end_of_output;
endmodule

// ===== bench/rle_byte_stream_expander_unit_tb.sv =====
// Testbench for rle_byte_stream_expander_unit: directed byte table, then random streams.
// A local run predictor checks every decoded run in order.
// Depends on rbse_pkg and the rle_byte_stream_expander_unit RTL.
`timescale 1ns / 1ps

module rle_byte_stream_expander_unit_tb;
  import rbse_pkg::*;

  // Directed row: one input byte, plus a hand-written expected run where fixed_exp is set
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       fixed_exp;
    run_t       exp;
  } dir_row_t;

  localparam int NumDirRows = 21;
  localparam int RandItems  = 1650;

  localparam dir_row_t DirRows [NumDirRows] = '{
    // stream ends on first header byte: empty end item
    {8'h00, 1'b1, 1'b1, 8'h00, 8'd0,   1'b0, 1'b1},
    // output length 5
    {8'h05, 1'b0, 1'b0, 18'h0},
    {8'h00, 1'b0, 1'b0, 18'h0},
    {8'h00, 1'b0, 1'b0, 18'h0},
    {8'h00, 1'b0, 1'b0, 18'h0},
    // shortest repeat
    {8'h00, 1'b0, 1'b0, 18'h0},
    {8'hFF, 1'b0, 1'b1, 8'hFF, 8'd3,   1'b0, 1'b0},
    // two literal bytes fill the output
    {8'h81, 1'b0, 1'b0, 18'h0},
    {8'hAA, 1'b0, 1'b1, 8'hAA, 8'd1,   1'b0, 1'b0},
    {8'h55, 1'b0, 1'b1, 8'h55, 8'd1,   1'b0, 1'b0},
    // longest repeat, output already full
    {8'h7F, 1'b0, 1'b0, 18'h0},
    {8'h00, 1'b0, 1'b1, 8'h00, 8'd0,   1'b1, 1'b0},
    // longest literal cut short by the end of the stream
    {8'hFF, 1'b0, 1'b0, 18'h0},
    {8'h12, 1'b1, 1'b1, 8'h12, 8'd0,   1'b1, 1'b1},
    // largest output length
    {8'hFF, 1'b0, 1'b0, 18'h0},
    {8'hFF, 1'b0, 1'b0, 18'h0},
    {8'hFF, 1'b0, 1'b0, 18'h0},
    {8'hFF, 1'b0, 1'b0, 18'h0},
    {8'h7F, 1'b0, 1'b0, 18'h0},
    {8'h3C, 1'b0, 1'b1, 8'h3C, 8'd130, 1'b0, 1'b0},
    // final control byte is dropped: empty end item
    {8'h80, 1'b1, 1'b1, 8'h00, 8'd0,   1'b0, 1'b1}
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_end    = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic [7:0] run_count_o;
  logic       clipped_o;
  logic       end_of_output_o;

  // Predictor state
  phase_e      dec_phase   = PH_HEADER;
  logic [1:0]  hdr_pos     = '0;
  logic [31:0] out_limit   = '0;
  logic [31:0] out_written = '0;
  logic [7:0]  lit_left    = '0;
  logic [7:0]  rep_len     = '0;

  run_t pending_runs[$];
  int   fail_cnt   = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  int   ready_run  = 0;
  int   stall_run  = 0;

  rle_byte_stream_expander_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte),
    .stream_end_i   (in_end),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte_o),
    .run_count_o    (run_count_o),
    .clipped_o      (clipped_o),
    .end_of_output_o(end_of_output_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clip a run of n copies of b to the room left in the output
  function automatic run_t clip_run(input logic [7:0] b, input logic [31:0] n,
                                    input logic last);
    run_t        r;
    logic [31:0] room;
    logic [31:0] take;
    room = out_limit - out_written;
    take = (n < room) ? n : room;
    out_written = out_written + take;
    r.out_byte      = b;
    r.run_count     = take[7:0];
    r.clipped       = (take < n);
    r.end_of_output = last;
    return r;
  endfunction

  // Advance the decoder by one compressed byte; return 1 when a run comes out
  function automatic bit expand_byte(input logic [7:0] b, input logic last, output run_t r);
    bit got_run;
    got_run = 1'b0;
    r = '0;
    case (dec_phase)
      PH_HEADER: begin
        out_limit = out_limit | (32'(b) << (8 * hdr_pos));
        if (hdr_pos == HeaderLast) dec_phase = PH_CONTROL;
        hdr_pos = hdr_pos + 2'd1;
      end
      PH_CONTROL: begin
        if (b >= LitThreshold) begin
          lit_left  = b - LitOffset;
          dec_phase = PH_LITERAL;
        end else begin
          rep_len   = b + RepOffset;
          dec_phase = PH_REPEAT;
        end
      end
      PH_LITERAL: begin
        r = clip_run(b, 32'd1, last);
        got_run = 1'b1;
        lit_left = lit_left - 8'd1;
        if (lit_left == 8'd0) dec_phase = PH_CONTROL;
      end
      default: begin
        r = clip_run(b, 32'(rep_len), last);
        got_run = 1'b1;
        dec_phase = PH_CONTROL;
      end
    endcase
    // End of stream: emit an empty end item if needed, then start over
    if (last) begin
      if (!got_run) begin
        r = '0;
        r.end_of_output = 1'b1;
        got_run = 1'b1;
      end
      dec_phase   = PH_HEADER;
      hdr_pos     = '0;
      out_limit   = '0;
      out_written = '0;
      lit_left    = '0;
      rep_len     = '0;
    end
    return got_run;
  endfunction

  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Offer one byte and hold it until the transfer; gaps fall between bursts
  task automatic push_byte(input logic [7:0] b, input logic last, input logic fixed_exp,
                           input run_t exp);
    run_t r;
    bit   got_run;
    int   gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    got_run = expand_byte(b, last, r);
    if (fixed_exp) pending_runs.push_back(exp);
    else if (got_run) pending_runs.push_back(r);
    in_valid <= 1'b1;
    in_byte  <= b;
    in_end   <= last;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Build one stream: mostly well formed, some cut short, some pure noise
  task automatic send_stream();
    logic [7:0]  bytes_q[$];
    logic [31:0] lim;
    int          kind;
    int          nseg;
    int          len;
    int          cut;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      len = $urandom_range(1, 16);
      repeat (len) bytes_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 3))
        0:       lim = $urandom_range(0, 24);
        1:       lim = $urandom_range(0, 400);
        2:       lim = $urandom;
        default: lim = 32'hFFFF_FFFF;
      endcase
      for (int i = 0; i < 4; i++) bytes_q.push_back(lim[8*i +: 8]);
      nseg = $urandom_range(1, 6);
      repeat (nseg) begin
        if ($urandom_range(0, 1) == 1) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 128) : $urandom_range(1, 8);
          bytes_q.push_back(8'(len) + LitOffset);
          repeat (len) bytes_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          bytes_q.push_back(8'($urandom_range(0, 127)));
          bytes_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      // dangling control byte at the end now and then
      if ($urandom_range(0, 7) == 0) bytes_q.push_back(8'($urandom_range(0, 255)));
      // broken stream: end it anywhere
      if (kind == 1) begin
        cut = $urandom_range(1, bytes_q.size());
        while (bytes_q.size() > cut) void'(bytes_q.pop_back());
      end
    end
    foreach (bytes_q[i]) push_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b0, '0);
  endtask

  // Receiver: runs of ready cycles broken by stalls of random length
  always @(posedge clk) begin
    if (ready_run > 0) begin
      out_ready <= 1'b1;
      ready_run--;
    end else if (stall_run > 0) begin
      out_ready <= 1'b0;
      stall_run--;
    end else begin
      out_ready <= 1'b1;
      ready_run = $urandom_range(0, 24);
      stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
  end

  // Check each output transfer against the oldest expected run
  always @(posedge clk) begin
    run_t exp_run;
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_runs.size() == 0) begin
        note_failure($sformatf("unexpected run byte=%h count=%0d clipped=%b end=%b",
                               out_byte_o, run_count_o, clipped_o, end_of_output_o));
      end else begin
        exp_run = pending_runs.pop_front();
        if (out_byte_o !== exp_run.out_byte || run_count_o !== exp_run.run_count ||
            clipped_o !== exp_run.clipped || end_of_output_o !== exp_run.end_of_output) begin
          note_failure($sformatf(
            {"run mismatch: exp byte=%h count=%0d clipped=%b end=%b, ",
             "got byte=%h count=%0d clipped=%b end=%b"},
            exp_run.out_byte, exp_run.run_count, exp_run.clipped, exp_run.end_of_output,
            out_byte_o, run_count_o, clipped_o, end_of_output_o));
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < NumDirRows; i++) begin
      push_byte(DirRows[i].b, DirRows[i].last, DirRows[i].fixed_exp, DirRows[i].exp);
    end
    while (items_sent < NumDirRows + RandItems) send_stream();
    in_valid <= 1'b0;
    // drain, then watch a little longer for stray runs
    for (int k = 0; k < 5000 && pending_runs.size() != 0; k++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_runs.size() != 0) note_failure("expected runs never arrived");
    if (fail_cnt == 0) begin
      $display("PASS rle_byte_stream_expander_unit");
    end else begin
      $display("FAIL rle_byte_stream_expander_unit");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #3_000_000;
    $display("FAIL rle_byte_stream_expander_unit");
    $finish;
  end

endmodule
